// ===== src/fxalu_pkg.sv =====
// shared types and command codes for the q24.8 arithmetic unit
`default_nettype none
package fxalu_pkg;

  typedef enum logic [3:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdGt      = 4'd4,
    CmdLt      = 4'd5,
    CmdGe      = 4'd6,
    CmdLe      = 4'd7,
    CmdEq      = 4'd8,
    CmdNe      = 4'd9,
    CmdInc     = 4'd10,
    CmdDec     = 4'd11,
    CmdMin     = 4'd12,
    CmdMax     = 4'd13,
    CmdFromInt = 4'd14,
    CmdToInt   = 4'd15
  } cmd_e;

  // register stages inside the multiplier
  localparam int unsigned MulLat = 3;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_word_t;

  // what the simple path leaves for the final stage
  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
  } simple_t;

endpackage
`default_nettype wire

// ===== src/fxalu_mul.sv =====
// pipelined magnitude multiplier with rounding and saturation
`default_nettype none
module fxalu_mul #(
  parameter int unsigned FracBits = 8
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] mag_a_i,
  input  wire logic [31:0] mag_b_i,
  input  wire logic        neg_i,
  output logic [31:0]      res_o
);
  // stage 1: four 16x16 partial products
  logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic        neg1_q;
  // stage 2: summed product
  logic [63:0] prod_q;
  logic        neg2_q;
  // stage 3: rounded magnitude
  logic [63:0] rnd_q;
  logic        neg3_q;
  logic [63:0] prod_d, rnd_d;
  logic [32:0] padj;

  assign prod_d = {32'd0, pp_ll_q} + ({32'd0, pp_lh_q} << 16) + ({32'd0, pp_hl_q} << 16)
                + {pp_hh_q, 32'd0};
  assign rnd_d  = (prod_q + (64'd1 << (FracBits - 1))) >> FracBits;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= mag_a_i[15:0] * mag_b_i[15:0];
      pp_lh_q <= mag_a_i[15:0] * mag_b_i[31:16];
      pp_hl_q <= mag_a_i[31:16] * mag_b_i[15:0];
      pp_hh_q <= mag_a_i[31:16] * mag_b_i[31:16];
      neg1_q  <= neg_i;
      prod_q  <= prod_d;
      neg2_q  <= neg1_q;
      rnd_q   <= rnd_d;
      neg3_q  <= neg2_q;
    end
  end

  // saturate to signed 32 bits
  always_comb begin
    padj = 33'd0 - {1'b0, rnd_q[31:0]};
    if (neg3_q) begin
      res_o = (rnd_q >= 64'h8000_0000) ? 32'h8000_0000 : padj[31:0];
    end else begin
      res_o = (rnd_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd_q[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/fxalu_div.sv =====
// pipelined restoring divider, a few quotient bits per stage
`default_nettype none
module fxalu_div #(
  parameter int unsigned FracBits = 8,
  parameter int unsigned Steps    = 8
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] mag_a_i,
  input  wire logic [31:0] mag_b_i,
  input  wire logic        neg_i,
  output logic [31:0]      res_o
);
  localparam int unsigned NumW  = 32 + FracBits;
  localparam int unsigned PerSt = (NumW + Steps - 1) / Steps;
  localparam int unsigned TotW  = PerSt * Steps;

  // per stage: partial remainder, remaining dividend bits, quotient
  logic [32:0]     rem_q [Steps+1];
  logic [TotW-1:0] num_q [Steps+1];
  logic [TotW-1:0] quo_q [Steps+1];
  logic [31:0]     den_q [Steps+1];
  logic            neg_q [Steps+1];

  always_comb begin
    rem_q[0] = 33'd0;
    num_q[0] = TotW'({mag_a_i, FracBits'(0)});
    quo_q[0] = '0;
    den_q[0] = mag_b_i;
    neg_q[0] = neg_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_st
    logic [32:0]     r;
    logic [TotW-1:0] n, q;
    always_comb begin
      r = rem_q[s];
      n = num_q[s];
      q = quo_q[s];
      for (int k = 0; k < PerSt; k++) begin
        r = {r[31:0], n[TotW-1]};
        n = {n[TotW-2:0], 1'b0};
        if (r >= {1'b0, den_q[s]}) begin
          r = r - {1'b0, den_q[s]};
          q = {q[TotW-2:0], 1'b1};
        end else begin
          q = {q[TotW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r;
        num_q[s+1] <= n;
        quo_q[s+1] <= q;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  // round half away, then saturate
  logic [TotW:0] qr;
  logic [33:0]   r2;
  logic [32:0]   nadj;
  always_comb begin
    r2 = {rem_q[Steps], 1'b0};
    qr = {1'b0, quo_q[Steps]} + {{TotW{1'b0}}, (r2 >= {2'b0, den_q[Steps]})};
    nadj = 33'd0 - {1'b0, qr[31:0]};
    if (neg_q[Steps]) begin
      res_o = (qr >= (TotW+1)'(33'h0_8000_0000)) ? 32'h8000_0000 : nadj[31:0];
    end else begin
      res_o = (qr > (TotW+1)'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : qr[31:0];
    end
  end
endmodule
`default_nettype wire

// ===== src/fixed_point_alu_q24_8_unit.sv =====
// top level of the q24.8 fixed-point arithmetic unit
// Usage: words enter on in_valid_i/in_stall_o carrying a command and two raw
// q24.8 operands; each word gives exactly one result word on
// out_valid_o/out_stall_i. A word is taken at a clock edge where valid is
// high and stall is low.
// Pipeline depth: Depth = DivSteps register stages from acceptance to
// out_valid_o; the restoring divider pipeline sets this depth, and the
// multiplier and simple operations are delayed to match.
// Throughput: one word per cycle while the output is not stalled. The whole
// pipeline advances together; a stall at the output freezes every stage, and
// in_stall_o is high exactly while a finished word waits at the output under
// out_stall_i; bubbles inside the pipeline are not squeezed out.
// Reset: rst_ni clears all valid bits; the data pipeline registers are not reset.
`default_nettype none
module fixed_point_alu_q24_8_unit #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned DivSteps  = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire fxalu_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output fxalu_pkg::out_word_t      out_word_o
);
  import fxalu_pkg::*;

  localparam int unsigned Depth = DivSteps;

  logic        en;
  logic [Depth-1:0] vld_q;
  logic [31:0] mag_a, mag_b;
  logic        neg;
  logic signed [31:0] a, b;
  simple_t     simp_d;
  simple_t     simp_q [Depth];
  cmd_e        cmd_q  [Depth];
  logic        dz_q   [Depth];
  logic [31:0] mul_res, div_res, mul_pipe_q [Depth-MulLat];

  // pipeline advances unless a finished word is stalled
  assign en         = !(vld_q[Depth-1] && out_stall_i);
  assign in_stall_o = !en;

  assign a     = in_word_i.operand_a;
  assign b     = in_word_i.operand_b;
  assign mag_a = a[31] ? 32'd0 - a : a;
  assign mag_b = b[31] ? 32'd0 - b : b;
  assign neg   = a[31] ^ b[31];

  // commands computed combinationally at the input
  always_comb begin
    simp_d = '0;
    case (cmd_e'(in_word_i.command))
      CmdAdd:     simp_d.value = a + b;
      CmdSub:     simp_d.value = a - b;
      CmdGt:      simp_d.cmp = a > b;
      CmdLt:      simp_d.cmp = a < b;
      CmdGe:      simp_d.cmp = a >= b;
      CmdLe:      simp_d.cmp = a <= b;
      CmdEq:      simp_d.cmp = a == b;
      CmdNe:      simp_d.cmp = a != b;
      CmdInc:     simp_d.value = a + 32'sd1;
      CmdDec:     simp_d.value = a - 32'sd1;
      CmdMin:     simp_d.value = (a < b) ? a : b;
      CmdMax:     simp_d.value = (a > b) ? a : b;
      CmdFromInt: simp_d.value = a << FRAC_BITS;
      CmdToInt:   simp_d.value = a >>> FRAC_BITS;
      default:    simp_d = '0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // side-band delay line
  always_ff @(posedge clk_i) begin
    if (en) begin
      simp_q[0] <= simp_d;
      cmd_q[0]  <= cmd_e'(in_word_i.command);
      dz_q[0]   <= (b == 32'sd0);
      for (int i = 1; i < Depth; i++) begin
        simp_q[i] <= simp_q[i-1];
        cmd_q[i]  <= cmd_q[i-1];
        dz_q[i]   <= dz_q[i-1];
      end
      mul_pipe_q[0] <= mul_res;
      for (int i = 1; i < Depth - MulLat; i++) begin
        mul_pipe_q[i] <= mul_pipe_q[i-1];
      end
    end
  end

  fxalu_mul #(.FracBits(FRAC_BITS)) u_mul (
    .clk_i, .en_i(en), .mag_a_i(mag_a), .mag_b_i(mag_b), .neg_i(neg), .res_o(mul_res)
  );

  fxalu_div #(.FracBits(FRAC_BITS), .Steps(DivSteps)) u_div (
    .clk_i, .en_i(en), .mag_a_i(mag_a), .mag_b_i(mag_b), .neg_i(neg), .res_o(div_res)
  );

  // result select
  always_comb begin
    out_word_o = '0;
    case (cmd_q[Depth-1])
      CmdMul: out_word_o.result_value = mul_pipe_q[Depth-MulLat-1];
      CmdDiv: begin
        out_word_o.divide_by_zero = dz_q[Depth-1];
        out_word_o.result_value   = dz_q[Depth-1] ? 32'sd0 : div_res;
      end
      default: begin
        out_word_o.result_value = simp_q[Depth-1].value;
        out_word_o.compare_true = simp_q[Depth-1].cmp;
      end
    endcase
  end

  assign out_valid_o = vld_q[Depth-1];
endmodule
`default_nettype wire
